@@ rtl/core/dct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_pkg
// Shared types, letters and the standard genetic code for the codon translator
// ----------------------------------------------------------------------------
package dct_pkg;

    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REVERSE_STRAND  = 2'd0,
        CFG_KEEP_FINAL_STOP = 2'd1,
        CFG_ALT_START_MASK  = 2'd2,
        CFG_ALT_STOP_MASK   = 2'd3
    } cfg_index_t;

    localparam logic [7:0] CHAR_X    = 8'h58;
    localparam logic [7:0] CHAR_M    = 8'h4D;
    localparam logic [7:0] CHAR_STOP = 8'h2A;

    localparam logic [511:0] CODE_STR =
        "KNKNIIMIRSRSTTTT*Y*YLFLF*CWCSSSSEDEDVVVVGGGGAAAAQHQHLLLLRRRRPPPP";

    typedef struct packed {
        logic [3:0] base_mask;
        logic       last_base;
    } dct_in_t;

    typedef struct packed {
        logic [7:0] residue;
        logic       residue_valid;
        logic       end_of_protein;
    } dct_out_t;

    // one codon handed from the base collector to the residue unit
    typedef struct packed {
        logic [3:0] b0;
        logic [3:0] b1;
        logic [3:0] b2;
        logic       partial;
        logic       first;
        logic       last;
    } dct_codon_t;

    typedef struct packed {
        logic        reverse_strand;
        logic        keep_final_stop;
        logic [63:0] alt_start_mask;
        logic [63:0] alt_stop_mask;
    } dct_cfg_t;

    // letter of codon index (x<<4)|(y<<2)|z, first character at index 0
    function automatic logic [7:0] code_letter(input logic [5:0] idx);
        logic [8:0] bit_pos;
        bit_pos = {~idx, 3'b000};
        return CODE_STR[bit_pos +: 8];
    endfunction

    function automatic logic [3:0] complement_mask(input logic [3:0] m);
        return {m[2], m[3], m[0], m[1]};
    endfunction

    // position of the lowest set bit, 0 when empty
    function automatic logic [1:0] lowest_base(input logic [3:0] m);
        logic [1:0] pos;
        pos = 2'd0;
        priority if (m[0]) pos = 2'd0;
        else if (m[1]) pos = 2'd1;
        else if (m[2]) pos = 2'd2;
        else if (m[3]) pos = 2'd3;
        else pos = 2'd0;
        return pos;
    endfunction

endpackage

@@ rtl/core/dct_residue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_residue_unit
// Resolves one codon of ambiguity masks to its residue, with start/stop rules
// ----------------------------------------------------------------------------
module dct_residue_unit (
    input  dct_pkg::dct_codon_t codon,
    input  dct_pkg::dct_cfg_t   cfg,
    output dct_pkg::dct_out_t   result
);

    logic [3:0] ma;
    logic [3:0] mb;
    logic [3:0] mc;
    logic [5:0] idx;
    logic [7:0] first_letter;
    logic       nonempty;
    logic       mismatch;
    logic       ok;
    logic [7:0] letter;
    logic [7:0] after_start;
    logic [7:0] after_stop;

    always_comb begin
        if (cfg.reverse_strand) begin
            ma = dct_pkg::complement_mask(codon.b2);
            mb = dct_pkg::complement_mask(codon.b1);
            mc = dct_pkg::complement_mask(codon.b0);
        end else begin
            ma = codon.b0;
            mb = codon.b1;
            mc = codon.b2;
        end
    end

    assign nonempty = (ma != 4'd0) && (mb != 4'd0) && (mc != 4'd0);
    assign idx = {dct_pkg::lowest_base(ma), dct_pkg::lowest_base(mb),
                  dct_pkg::lowest_base(mc)};
    assign first_letter = dct_pkg::code_letter(idx);

    // every expansion must give the letter of the lowest one
    always_comb begin
        mismatch = 1'b0;
        for (int i = 0; i < 64; i++) begin
            if (ma[i / 16] && mb[(i / 4) % 4] && mc[i % 4] &&
                (dct_pkg::code_letter(6'(i)) != first_letter)) begin
                mismatch = 1'b1;
            end
        end
    end

    assign ok     = nonempty && !mismatch;
    assign letter = ok ? first_letter : dct_pkg::CHAR_X;

    always_comb begin
        after_start = letter;
        if (codon.first && ok && (letter != dct_pkg::CHAR_M) &&
            cfg.alt_start_mask[idx]) begin
            after_start = dct_pkg::CHAR_M;
        end
        after_stop = after_start;
        if (codon.last && ok && (after_start != dct_pkg::CHAR_STOP) &&
            cfg.alt_stop_mask[idx]) begin
            after_stop = dct_pkg::CHAR_STOP;
        end
    end

    always_comb begin
        result.end_of_protein = codon.last;
        result.residue_valid  = 1'b1;
        if (codon.partial) begin
            result.residue = dct_pkg::CHAR_X;
        end else if (codon.last && !cfg.keep_final_stop &&
                     (after_stop == dct_pkg::CHAR_STOP)) begin
            result.residue       = 8'd0;
            result.residue_valid = 1'b0;
        end else begin
            result.residue = after_stop;
        end
    end

endmodule

@@ rtl/core/dna_codon_translator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_codon_translator
// Groups a base stream into codons and emits one residue per codon
// ----------------------------------------------------------------------------
// the base that completes a codon loads the codon register; its residue then
//   passes to the result register, from which it is transferred
// throughput: one base per cycle, limited only by result back-pressure
// reset: clears configuration to zero and the codon state to the start of a
//   sequence; no memories to clear
module dna_codon_translator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [dct_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dct_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  dct_pkg::dct_in_t                  s_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output dct_pkg::dct_out_t                 m_payload
);

    dct_pkg::dct_cfg_t   cfg_reg;
    logic [7:0]          held_reg;
    logic [7:0]          held_next;
    logic [1:0]          phase_reg;
    logic [1:0]          phase_next;
    logic                first_reg;
    logic                first_next;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    dct_pkg::dct_codon_t s1_codon_reg;
    dct_pkg::dct_codon_t s1_codon_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    dct_pkg::dct_out_t   m_payload_reg;
    dct_pkg::dct_out_t   residue_out;
    logic                in_xfer;
    logic                out_free;
    logic                s1_move;
    logic                s1_load;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (dct_pkg::cfg_index_t'(cfg_index))
                dct_pkg::CFG_REVERSE_STRAND:  cfg_reg.reverse_strand  <= cfg_wr_data[0];
                dct_pkg::CFG_KEEP_FINAL_STOP: cfg_reg.keep_final_stop <= cfg_wr_data[0];
                dct_pkg::CFG_ALT_START_MASK:  cfg_reg.alt_start_mask  <= cfg_wr_data;
                dct_pkg::CFG_ALT_STOP_MASK:   cfg_reg.alt_stop_mask   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign in_xfer  = s_valid && s_ready;

    // base collection
    always_comb begin
        held_next     = held_reg;
        phase_next    = phase_reg;
        first_next    = first_reg;
        s1_load       = 1'b0;
        s1_codon_next = s1_codon_reg;
        if (in_xfer) begin
            if (phase_reg != 2'd2) begin
                if (s_payload.last_base) begin
                    s1_load               = 1'b1;
                    s1_codon_next         = '0;
                    s1_codon_next.partial = 1'b1;
                    s1_codon_next.last    = 1'b1;
                    held_next             = '0;
                    phase_next            = 2'd0;
                    first_next            = 1'b1;
                end else begin
                    if (phase_reg == 2'd0) begin
                        held_next = {4'd0, s_payload.base_mask};
                    end else begin
                        held_next = {s_payload.base_mask, held_reg[3:0]};
                    end
                    phase_next = phase_reg + 2'd1;
                end
            end else begin
                s1_load               = 1'b1;
                s1_codon_next.b0      = held_reg[3:0];
                s1_codon_next.b1      = held_reg[7:4];
                s1_codon_next.b2      = s_payload.base_mask;
                s1_codon_next.partial = 1'b0;
                s1_codon_next.first   = first_reg;
                s1_codon_next.last    = s_payload.last_base;
                held_next             = '0;
                phase_next            = 2'd0;
                first_next            = s_payload.last_base;
            end
        end
    end

    always_comb begin
        if (s1_load) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        if (s1_move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg     <= '0;
            phase_reg    <= 2'd0;
            first_reg    <= 1'b1;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            held_reg     <= held_next;
            phase_reg    <= phase_next;
            first_reg    <= first_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_codon_reg <= s1_codon_next;
        if (s1_move) begin
            m_payload_reg <= residue_out;
        end
    end

    dct_residue_unit u_residue (
        .codon  (s1_codon_reg),
        .cfg    (cfg_reg),
        .result (residue_out)
    );

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

@@ dv/residue_check_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// residue_check_pkg
// Residue predictor and scoreboard for the codon translator: mirrors the codon
// state and configuration, predicts each residue and checks the result stream
// ----------------------------------------------------------------------------
package residue_check_pkg;

    import dct_pkg::*;

    class residue_scoreboard;

        bit          reverse_strand;
        bit          keep_final_stop;
        logic [63:0] start_mask;
        logic [63:0] stop_mask;
        logic [7:0]  held_bases;
        int unsigned codon_phase;
        bit          first_codon;
        dct_out_t    expected_residues[$];
        int unsigned failures;

        function new();
            reverse_strand  = 1'b0;
            keep_final_stop = 1'b0;
            start_mask      = '0;
            stop_mask       = '0;
            failures        = 0;
            restart_strand();
        endfunction

        function void restart_strand();
            held_bases  = '0;
            codon_phase = 0;
            first_codon = 1'b1;
        endfunction

        function void configure(cfg_index_t idx, logic [63:0] value);
            case (idx)
                CFG_REVERSE_STRAND:  reverse_strand  = value[0];
                CFG_KEEP_FINAL_STOP: keep_final_stop = value[0];
                CFG_ALT_START_MASK:  start_mask      = value;
                CFG_ALT_STOP_MASK:   stop_mask       = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_residues.size();
        endfunction

        function logic [7:0] table_letter(logic [5:0] codon_idx);
            return CODE_STR[8 * (63 - int'(codon_idx)) +: 8];
        endfunction

        function logic [3:0] opposite_base(logic [3:0] m);
            return ((m & 4'b0101) << 1) | ((m & 4'b1010) >> 1);
        endfunction

        // letter all expansions agree on, else X; lowest expansion index returned
        function logic [7:0] resolve_codon(logic [3:0] m0, logic [3:0] m1, logic [3:0] m2,
                                           output logic [5:0] first_idx, output bit agreed);
            logic [7:0] letter;
            logic [5:0] codon_idx;
            letter    = 8'd0;
            first_idx = '0;
            agreed    = 1'b0;
            for (int x = 0; x < 4; x++) begin
                for (int y = 0; y < 4; y++) begin
                    for (int z = 0; z < 4; z++) begin
                        if (m0[x] && m1[y] && m2[z]) begin
                            codon_idx = 6'(x * 16 + y * 4 + z);
                            if (letter == 8'd0) begin
                                letter    = table_letter(codon_idx);
                                first_idx = codon_idx;
                            end else if (table_letter(codon_idx) != letter) begin
                                return CHAR_X;
                            end
                        end
                    end
                end
            end
            if (letter == 8'd0)
                return CHAR_X;
            agreed = 1'b1;
            return letter;
        endfunction

        function void note_base(dct_in_t item);
            logic [3:0] m0, m1, m2;
            logic [5:0] codon_idx;
            logic [7:0] letter;
            bit         agreed;
            dct_out_t   res;
            if (codon_phase < 2) begin
                if (codon_phase == 0)
                    held_bases = {4'd0, item.base_mask};
                else
                    held_bases[7:4] = item.base_mask;
                if (!item.last_base) begin
                    codon_phase++;
                    return;
                end
                // partial codon at the end of the strand
                res.residue        = CHAR_X;
                res.residue_valid  = 1'b1;
                res.end_of_protein = 1'b1;
                expected_residues.push_back(res);
                restart_strand();
                return;
            end
            m0 = held_bases[3:0];
            m1 = held_bases[7:4];
            m2 = item.base_mask;
            if (reverse_strand)
                letter = resolve_codon(opposite_base(m2), opposite_base(m1),
                                       opposite_base(m0), codon_idx, agreed);
            else
                letter = resolve_codon(m0, m1, m2, codon_idx, agreed);
            if (first_codon && agreed && letter != CHAR_M && start_mask[codon_idx])
                letter = CHAR_M;
            res.residue_valid  = 1'b1;
            res.end_of_protein = item.last_base;
            if (item.last_base) begin
                if (agreed && letter != CHAR_STOP && stop_mask[codon_idx])
                    letter = CHAR_STOP;
                if (!keep_final_stop && letter == CHAR_STOP) begin
                    letter            = 8'd0;
                    res.residue_valid = 1'b0;
                end
                restart_strand();
            end else begin
                held_bases  = '0;
                codon_phase = 0;
                first_codon = 1'b0;
            end
            res.residue = letter;
            expected_residues.push_back(res);
        endfunction

        function void check_residue(dct_out_t got);
            dct_out_t want;
            if (expected_residues.size() == 0) begin
                $error("unexpected result transfer: residue %h valid %b end %b",
                       got.residue, got.residue_valid, got.end_of_protein);
                failures++;
                return;
            end
            want = expected_residues.pop_front();
            if (got.residue !== want.residue) begin
                $error("residue: expected %h, actual %h", want.residue, got.residue);
                failures++;
            end
            if (got.residue_valid !== want.residue_valid) begin
                $error("residue_valid: expected %b, actual %b",
                       want.residue_valid, got.residue_valid);
                failures++;
            end
            if (got.end_of_protein !== want.end_of_protein) begin
                $error("end_of_protein: expected %b, actual %b",
                       want.end_of_protein, got.end_of_protein);
                failures++;
            end
        endfunction

    endclass

endpackage

@@ dv/dna_codon_translator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_codon_translator_test
// Drives base strands through the codon translator under a series of strand,
// start and stop settings with random gaps and back-pressure, and checks every
// residue against a scoreboard that predicts it from the accepted bases
// ----------------------------------------------------------------------------
module dna_codon_translator_test;

    import dct_pkg::*;
    import residue_check_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_PHASES  = 8;
    localparam int ITEMS_PER_PHASE = 235;

    localparam logic [3:0] BASE_A    = 4'b0001;
    localparam logic [3:0] BASE_T    = 4'b0010;
    localparam logic [3:0] BASE_G    = 4'b0100;
    localparam logic [3:0] BASE_C    = 4'b1000;
    localparam logic [3:0] BASE_ANY  = 4'b1111;
    localparam logic [3:0] BASE_NONE = 4'b0000;

    // forward start and its reverse-strand image
    localparam logic [11:0] START_CODONS [2] = '{
        {BASE_A, BASE_T, BASE_G}, {BASE_C, BASE_A, BASE_T}
    };
    // forward stops and their reverse-strand images
    localparam logic [11:0] STOP_CODONS [6] = '{
        {BASE_T, BASE_A, BASE_A}, {BASE_T, BASE_A, BASE_G}, {BASE_T, BASE_G, BASE_A},
        {BASE_T, BASE_T, BASE_A}, {BASE_C, BASE_T, BASE_A}, {BASE_T, BASE_C, BASE_A}
    };

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    cfg_index_t cfg_index   = CFG_REVERSE_STRAND;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    dct_in_t    s_payload   = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    dct_out_t   m_payload;

    residue_scoreboard book;
    int unsigned       cycle_count = 0;
    int unsigned       items_sent  = 0;
    int                idle_pct    = 0;
    int                stall_pct   = 0;

    dna_codon_translator i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // transfer monitor on both channels
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            book.note_base(s_payload);
        if (aresetn && m_valid && m_ready)
            book.check_residue(m_payload);
    end

    // result back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_pct != 0 && $urandom_range(99) < 2) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic int pick_pct();
        case ($urandom_range(3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    function automatic int sender_gap();
        if (idle_pct == 0 || $urandom_range(99) >= idle_pct)
            return 0;
        if ($urandom_range(19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [63:0] random_mask();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return {$urandom, $urandom};
            default: return (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63));
        endcase
    endfunction

    function automatic logic [3:0] random_base();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return BASE_A << $urandom_range(3);
        if (r < 90)
            return 4'($urandom_range(15));
        return BASE_ANY;
    endfunction

    // sender holds off until every residue has arrived
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (book.pending() != 0);
    endtask

    task automatic apply_settings(bit rev, bit keep, logic [63:0] start_bits,
                                  logic [63:0] stop_bits);
        cfg_index_t  regs [4];
        logic [63:0] values [4];
        regs   = '{CFG_REVERSE_STRAND, CFG_KEEP_FINAL_STOP, CFG_ALT_START_MASK,
                   CFG_ALT_STOP_MASK};
        values = '{64'(rev), 64'(keep), start_bits, stop_bits};
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= regs[i];
            cfg_wr_data <= values[i];
            @(posedge aclk);
            book.configure(regs[i], values[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_base(dct_in_t item);
        int gap;
        s_valid   <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        gap = sender_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_strand(logic [3:0] strand[$]);
        dct_in_t item;
        foreach (strand[i]) begin
            item.base_mask = strand[i];
            item.last_base = (i == strand.size() - 1);
            send_base(item);
        end
    endtask

    task automatic send_random_strand();
        logic [3:0]  strand[$];
        logic [11:0] codon;
        int          len;
        int          r;
        r = $urandom_range(99);
        if (r < 10)
            len = $urandom_range(1, 2);
        else if (r < 30)
            len = $urandom_range(3, 40);
        else
            len = 3 * $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
            strand.push_back(random_base());
        if (len >= 3 && $urandom_range(2) == 0) begin
            codon = START_CODONS[$urandom_range(1)];
            strand[0] = codon[11:8];
            strand[1] = codon[7:4];
            strand[2] = codon[3:0];
        end
        if (len % 3 == 0 && $urandom_range(4) < 2) begin
            codon = STOP_CODONS[$urandom_range(5)];
            strand[len-3] = codon[11:8];
            strand[len-2] = codon[7:4];
            strand[len-1] = codon[3:0];
        end
        if ($urandom_range(49) == 0)
            wait_drained();
        send_strand(strand);
    endtask

    initial begin
        logic [3:0] strand[$];
        int unsigned phase_start;
        book = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed strands, no gaps
        apply_settings(1'b0, 1'b0, '0, '0);
        strand = {BASE_A, BASE_T, BASE_G, BASE_T, BASE_A, BASE_A};
        send_strand(strand);
        strand = {BASE_ANY};
        send_strand(strand);
        strand = {BASE_NONE, BASE_C};
        send_strand(strand);
        // four-fold family agrees, then an empty mask at the end
        strand = {BASE_G, BASE_C, BASE_ANY, BASE_NONE, BASE_A, BASE_A};
        send_strand(strand);

        apply_settings(1'b1, 1'b1, '1, '1);
        strand = {BASE_C, BASE_A, BASE_T};
        send_strand(strand);
        strand = {BASE_T, BASE_T, BASE_T, BASE_ANY, BASE_ANY, BASE_ANY};
        send_strand(strand);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0)
                apply_settings(1'b1, 1'b0, '0, '0);
            else if (p == 1)
                apply_settings(1'b0, 1'b1, '1, '1);
            else
                apply_settings(1'($urandom_range(1)), 1'($urandom_range(1)),
                               random_mask(), random_mask());
            idle_pct  = pick_pct();
            stall_pct = pick_pct();
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
                send_random_strand();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (book.failures == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
